FILE: design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Buffer geometry and transfer constants
    localparam int SEND_DEPTH = 32;
    localparam int RECV_DEPTH = 16;
    localparam int RESTART_AT = 3;
    localparam int SEND_AW    = $clog2(SEND_DEPTH);

    localparam int SEND_POS_W = 6;
    localparam int RECV_POS_W = 5;

    localparam logic [SEND_POS_W-1:0] SEND_DEPTH_V = SEND_POS_W'(SEND_DEPTH);
    localparam logic [RECV_POS_W-1:0] RECV_DEPTH_V = RECV_POS_W'(RECV_DEPTH);
    localparam logic [SEND_POS_W-1:0] RESTART_AT_V = SEND_POS_W'(RESTART_AT);

    // R/W bit of the slave address byte
    localparam logic [7:0] READ_BIT = 8'h01;

    // Stream and config port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECV_COUNT   = 2'd2;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_BEGIN      = 3'd1,
        OP_START_SEEN = 3'd2,
        OP_STOP_SEEN  = 3'd3,
        OP_NACK       = 3'd4,
        OP_RX_FULL    = 3'd5,
        OP_TX_EMPTY   = 3'd6,
        OP_TX_END     = 3'd7
    } op_t;

    // Result word; last member sits in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       overrun;
        logic [1:0] irq_enables;
        logic       done_res;
        logic       stop_request;
        logic       restart_request;
        logic       start_request;
        logic       nack_bit;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } result_t;

endpackage

FILE: design/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Event-driven I2C master sequencer: write, read and write-then-read.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request: a request
// is captured in an input register, evaluated against the sequencer state
// by combinational logic, and the result is held in an output register. The
// state update is registered together with the result, so the next request
// sees it with no gap. The output register lets the
// input side keep accepting while a result waits to be taken; when both
// registers are full and the sink stalls, s_axis_tready drops. The send
// buffer is a 32 x 8 register file with no reset: entries must be loaded
// before use. Configuration writes are applied at once and should only be
// made while no request is in flight.
module i2c_master_transfer_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [i2cms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] opcode, [10:3] data_byte, [15:11] load_index
    input  logic [i2cms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] rx_valid, [17:10] rx_byte,
    // [21:18] rx_index, [22] nack_bit, [23] start_request,
    // [24] restart_request, [25] stop_request, [26] done_res,
    // [28:27] irq_enables, [29] overrun, [31:30] zero
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import i2cms_pkg::*;

    // Configuration registers
    logic                  restart_mode_reg;
    logic [5:0]            send_count_reg;
    logic [4:0]            recv_count_reg;

    // Input stage
    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [7:0]            s1_data_reg;
    logic [4:0]            s1_lidx_reg;

    // Output stage
    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    // Sequencer state
    logic [7:0]            send_buf_reg [SEND_DEPTH];
    logic [SEND_POS_W-1:0] send_pos_reg,  send_pos_next;
    logic [RECV_POS_W-1:0] recv_pos_reg,  recv_pos_next;
    logic                  dummy_reg,     dummy_next;
    logic                  done_reg,      done_next;
    logic                  txe_en_reg,    txe_en_next;
    logic                  txend_en_reg,  txend_en_next;

    logic                  advance;
    logic [SEND_POS_W-1:0] send_pos_inc;
    logic [RECV_POS_W-1:0] recv_pos_inc;
    logic [7:0]            buf_rd;
    logic                  send_in_range;

    // Handshake: input stage moves on when the output register is free
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_mode_reg <= 1'b0;
            send_count_reg   <= 6'd0;
            recv_count_reg   <= 5'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESTART_MODE: restart_mode_reg <= cfg_data[0];
                CFG_SEND_COUNT:   send_count_reg   <= cfg_data[5:0];
                CFG_RECV_COUNT:   recv_count_reg   <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_op_reg   <= op_t'(s_axis_tdata[2:0]);
            s1_data_reg <= s_axis_tdata[10:3];
            s1_lidx_reg <= s_axis_tdata[15:11];
        end
    end

    // Send buffer, written by load requests
    always_ff @(posedge clk)
    begin
        if (advance && s1_op_reg == OP_LOAD && {1'b0, s1_lidx_reg} < SEND_DEPTH_V)
            send_buf_reg[s1_lidx_reg[SEND_AW-1:0]] <= s1_data_reg;
    end

    assign send_in_range = send_pos_reg < SEND_DEPTH_V;
    assign buf_rd        = send_buf_reg[send_pos_reg[SEND_AW-1:0]];
    assign send_pos_inc  = send_pos_reg + 1'b1;
    assign recv_pos_inc  = recv_pos_reg + 1'b1;

    // Request evaluation
    always_comb
    begin
        send_pos_next = send_pos_reg;
        recv_pos_next = recv_pos_reg;
        dummy_next    = dummy_reg;
        done_next     = done_reg;
        txe_en_next   = txe_en_reg;
        txend_en_next = txend_en_reg;
        result_next   = '0;

        case (s1_op_reg)
            OP_LOAD: ;
            OP_BEGIN:
            begin
                send_pos_next             = '0;
                recv_pos_next             = '0;
                done_next                 = 1'b0;
                txe_en_next               = 1'b1;
                result_next.start_request = 1'b1;
            end
            OP_START_SEEN:
            begin
                // Repeated start reached: send the read address
                if (restart_mode_reg && send_pos_reg == RESTART_AT_V)
                begin
                    if (send_in_range)
                    begin
                        result_next.tx_valid = 1'b1;
                        result_next.tx_byte  = buf_rd;
                        send_pos_next        = send_pos_inc;
                        dummy_next           = 1'b1;
                        txend_en_next        = 1'b0;
                    end
                    else
                        result_next.overrun = 1'b1;
                end
            end
            OP_STOP_SEEN:
                done_next = 1'b1;
            OP_NACK:
                result_next.stop_request = 1'b1;
            OP_RX_FULL:
            begin
                if (dummy_reg)
                    dummy_next = 1'b0;
                else if (recv_pos_reg < RECV_DEPTH_V)
                begin
                    result_next.rx_valid = 1'b1;
                    result_next.rx_byte  = s1_data_reg;
                    result_next.rx_index = recv_pos_reg[3:0];
                    recv_pos_next        = recv_pos_inc;
                    // Last byte: NACK it and stop
                    if (recv_pos_inc >= recv_count_reg)
                    begin
                        result_next.nack_bit     = 1'b1;
                        result_next.stop_request = 1'b1;
                    end
                end
                else
                begin
                    result_next.overrun      = 1'b1;
                    result_next.nack_bit     = 1'b1;
                    result_next.stop_request = 1'b1;
                end
            end
            OP_TX_EMPTY:
            begin
                if (txe_en_reg)
                begin
                    if (!send_in_range)
                        result_next.overrun = 1'b1;
                    else
                    begin
                        result_next.tx_valid = 1'b1;
                        result_next.tx_byte  = buf_rd;
                        send_pos_next        = send_pos_inc;
                        if (restart_mode_reg)
                        begin
                            if (send_pos_inc == RESTART_AT_V)
                            begin
                                txe_en_next   = 1'b0;
                                txend_en_next = 1'b1;
                            end
                        end
                        else if ((send_buf_reg[0] & READ_BIT) != 8'd0)
                            dummy_next = 1'b1;
                        else if (send_pos_inc == send_count_reg)
                        begin
                            txe_en_next   = 1'b0;
                            txend_en_next = 1'b1;
                        end
                    end
                end
            end
            OP_TX_END:
            begin
                if (txend_en_reg)
                begin
                    if (restart_mode_reg)
                        result_next.restart_request = 1'b1;
                    else
                    begin
                        txend_en_next            = 1'b0;
                        result_next.stop_request = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        result_next.done_res    = done_next;
        result_next.irq_enables = {txend_en_next, txe_en_next};
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_pos_reg <= '0;
            recv_pos_reg <= '0;
            dummy_reg    <= 1'b0;
            done_reg     <= 1'b0;
            txe_en_reg   <= 1'b0;
            txend_en_reg <= 1'b0;
        end
        else if (advance)
        begin
            send_pos_reg <= send_pos_next;
            recv_pos_reg <= recv_pos_next;
            dummy_reg    <= dummy_next;
            done_reg     <= done_next;
            txe_en_reg   <= txe_en_next;
            txend_en_reg <= txend_en_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    // Checks
    a_send_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        send_pos_reg <= SEND_DEPTH_V)
        else $error("send position past buffer end");

    a_recv_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        recv_pos_reg <= RECV_DEPTH_V)
        else $error("receive position past buffer end");

    a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(result_reg.tx_valid && result_reg.rx_valid))
        else $error("transmit and receive in one result");

    a_overrun_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.overrun) |->
            (!result_reg.tx_valid && !result_reg.rx_valid))
        else $error("overrun result carries data");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("evaluated request produced no result");

endmodule

FILE: dv/sequencer_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequencer_result_checker
// Watches the config port and both streams of the I2C transfer sequencer.
// Every accepted request is run through a cycle-free model of the sequencer
// and the result it should produce is queued. Every accepted result is then
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module sequencer_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [i2cms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [i2cms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [i2cms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import i2cms_pkg::*;

    // Shadow copy of the sequencer state
    logic [7:0]            tx_buffer [SEND_DEPTH];
    logic [SEND_POS_W-1:0] send_pos;
    logic [RECV_POS_W-1:0] recv_pos;
    logic                  dummy_pending;
    logic                  done_flag;
    logic                  tx_empty_en;
    logic                  tx_end_en;

    // Shadow copy of the registers
    logic       restart_sel;
    logic [5:0] send_total;
    logic [4:0] recv_total;

    result_t expected_results [$];
    int      fail_total;
    result_t got;
    result_t want;

    // Apply one request to the shadow state, return the result it yields
    function automatic result_t predict_result(op_t op, logic [7:0] data,
                                               logic [4:0] idx);
        result_t r;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                tx_buffer[idx] = data;
            end
            OP_BEGIN:
            begin
                send_pos    = '0;
                recv_pos    = '0;
                done_flag   = 1'b0;
                tx_empty_en = 1'b1;
                r.start_request = 1'b1;
            end
            OP_START_SEEN:
            begin
                // only the repeated start of a write-then-read sends a byte
                if (restart_sel && send_pos == RESTART_AT_V)
                begin
                    if (send_pos < SEND_DEPTH_V)
                    begin
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = tx_buffer[send_pos[SEND_AW-1:0]];
                        send_pos      = send_pos + 1'b1;
                        dummy_pending = 1'b1;
                        tx_end_en     = 1'b0;
                    end
                    else
                    begin
                        r.overrun = 1'b1;
                    end
                end
            end
            OP_STOP_SEEN:
            begin
                done_flag = 1'b1;
            end
            OP_NACK:
            begin
                r.stop_request = 1'b1;
            end
            OP_RX_FULL:
            begin
                if (dummy_pending)
                begin
                    dummy_pending = 1'b0;
                end
                else if (recv_pos < RECV_DEPTH_V)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = data;
                    r.rx_index = recv_pos[3:0];
                    recv_pos   = recv_pos + 1'b1;
                    // last wanted byte: NACK it and close the transfer
                    if (recv_pos >= recv_total)
                    begin
                        r.nack_bit     = 1'b1;
                        r.stop_request = 1'b1;
                    end
                end
                else
                begin
                    r.overrun      = 1'b1;
                    r.nack_bit     = 1'b1;
                    r.stop_request = 1'b1;
                end
            end
            OP_TX_EMPTY:
            begin
                if (tx_empty_en)
                begin
                    if (send_pos >= SEND_DEPTH_V)
                    begin
                        r.overrun = 1'b1;
                    end
                    else
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_buffer[send_pos[SEND_AW-1:0]];
                        send_pos   = send_pos + 1'b1;
                        if (restart_sel)
                        begin
                            if (send_pos == RESTART_AT_V)
                            begin
                                tx_empty_en = 1'b0;
                                tx_end_en   = 1'b1;
                            end
                        end
                        else if ((tx_buffer[0] & READ_BIT) != 8'h00)
                        begin
                            dummy_pending = 1'b1;
                        end
                        else if (send_pos == send_total)
                        begin
                            tx_empty_en = 1'b0;
                            tx_end_en   = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // transmit end
                if (tx_end_en)
                begin
                    if (restart_sel)
                    begin
                        r.restart_request = 1'b1;
                    end
                    else
                    begin
                        tx_end_en      = 1'b0;
                        r.stop_request = 1'b1;
                    end
                end
            end
        endcase
        r.done_res    = done_flag;
        r.irq_enables = {tx_end_en, tx_empty_en};
        return r;
    endfunction

    function automatic int check_field(string name, int unsigned exp_val,
                                       int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    // Track config, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_pos       = '0;
            recv_pos       = '0;
            dummy_pending  = 1'b0;
            done_flag      = 1'b0;
            tx_empty_en    = 1'b0;
            tx_end_en      = 1'b0;
            restart_sel    = 1'b0;
            send_total     = 6'd0;
            recv_total     = 5'd2;
            fail_total     = 0;
            expected_results.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESTART_MODE: restart_sel = cfg_data[0];
                    CFG_SEND_COUNT:   send_total  = cfg_data[5:0];
                    CFG_RECV_COUNT:   recv_total  = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_result(op_t'(s_axis_tdata[2:0]),
                                                          s_axis_tdata[10:3],
                                                          s_axis_tdata[15:11]));
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result expected none actual %0h", $time, m_axis_tdata);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    fail_total += check_field("tx_valid", want.tx_valid, got.tx_valid);
                    fail_total += check_field("tx_byte", want.tx_byte, got.tx_byte);
                    fail_total += check_field("rx_valid", want.rx_valid, got.rx_valid);
                    fail_total += check_field("rx_byte", want.rx_byte, got.rx_byte);
                    fail_total += check_field("rx_index", want.rx_index, got.rx_index);
                    fail_total += check_field("nack_bit", want.nack_bit, got.nack_bit);
                    fail_total += check_field("start_request", want.start_request,
                                              got.start_request);
                    fail_total += check_field("restart_request", want.restart_request,
                                              got.restart_request);
                    fail_total += check_field("stop_request", want.stop_request,
                                              got.stop_request);
                    fail_total += check_field("done_res", want.done_res, got.done_res);
                    fail_total += check_field("irq_enables", want.irq_enables,
                                              got.irq_enables);
                    fail_total += check_field("overrun", want.overrun, got.overrun);
                    fail_total += check_field("pad", want.pad, got.pad);
                end
            end

            mismatch_count <= fail_total;
            pending_count  <= expected_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the I2C master transfer sequencer.
// Runs a short directed sweep (disabled events, overruns, every opcode), then
// phases of random write, read and write-then-read transfers with random
// content and some broken ones, under changing register settings and
// changing amounts of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import i2cms_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [2:0] opcode, [10:3] data_byte, [15:11] load_index
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] tx_valid, [8:1] tx_byte, [9] rx_valid, [17:10] rx_byte,
    // [21:18] rx_index, [22] nack_bit, [23] start_request,
    // [24] restart_request, [25] stop_request, [26] done_res,
    // [28:27] irq_enables, [29] overrun, [31:30] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_count;

    // Traffic shaping, shared with the sink process
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_off_pending = 1'b0;
    int requests_sent = 0;

    // Current register settings, used to shape well-formed transfers
    bit       restart_cur;
    int       send_cur;
    int       recv_cur;

    int src_pattern [4] = '{0, 51, 0, 12};
    int sink_pattern [4] = '{0, 0, 51, 12};

    always #5 clk = ~clk;

    i2c_master_transfer_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sequencer_result_checker result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Offer one request, with random idle cycles ahead of it
    task automatic issue(op_t op, logic [7:0] data, logic [4:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, data, op};
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Request with random fields, sometimes preceded by a random one
    task automatic step(op_t op);
        if ($urandom_range(99) < 8)
        begin
            issue(op_t'(3'($urandom_range(7))), 8'($urandom), 5'($urandom));
        end
        issue(op, 8'($urandom), 5'($urandom));
    endtask

    // Drain the block, then write all three registers
    task automatic program_transfer(bit rmode, logic [5:0] scount, logic [4:0] rcount);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RESTART_MODE;
        cfg_data  <= {5'b0, rmode};
        @(posedge clk);
        cfg_index <= CFG_SEND_COUNT;
        cfg_data  <= scount;
        @(posedge clk);
        cfg_index <= CFG_RECV_COUNT;
        cfg_data  <= {1'b0, rcount};
        @(posedge clk);
        cfg_we      <= 1'b0;
        restart_cur = rmode;
        send_cur    = scount;
        recv_cur    = rcount;
    endtask

    // One transfer shaped for the current settings, now and then broken
    task automatic random_transfer();
        bit broken;
        int n;
        broken = ($urandom_range(9) == 0);
        if ($urandom_range(3) == 0)
        begin
            step(OP_LOAD);
        end
        if (restart_cur)
        begin
            step(OP_BEGIN);
            n = broken ? $urandom_range(5) : RESTART_AT;
            repeat (n) step(OP_TX_EMPTY);
            step(OP_TX_END);
            step(OP_START_SEEN);
            step(OP_RX_FULL);
            n = broken ? $urandom_range(18) : recv_cur;
            repeat (n) step(OP_RX_FULL);
            step(OP_STOP_SEEN);
        end
        else if ($urandom_range(1))
        begin
            // plain write: even address byte
            issue(OP_LOAD, {7'($urandom), 1'b0}, 5'd0);
            step(OP_BEGIN);
            if (broken || send_cur == 0)
                n = $urandom_range(33);
            else
                n = send_cur;
            repeat (n) step(OP_TX_EMPTY);
            step(OP_TX_END);
            step(OP_STOP_SEEN);
        end
        else
        begin
            // plain read: odd address byte, one dummy read
            issue(OP_LOAD, {7'($urandom), 1'b1}, 5'd0);
            step(OP_BEGIN);
            step(OP_TX_EMPTY);
            step(OP_RX_FULL);
            n = broken ? $urandom_range(18) : recv_cur;
            repeat (n) step(OP_RX_FULL);
            step(OP_NACK);
            step(OP_STOP_SEEN);
        end
    endtask

    task automatic run_phase(bit rmode, logic [5:0] scount, logic [4:0] rcount,
                             int pattern, bit squeeze);
        int first;
        program_transfer(rmode, scount, rcount);
        src_idle_pct     = src_pattern[pattern];
        sink_stall_pct   = sink_pattern[pattern];
        hold_off_pending = squeeze;
        first = requests_sent;
        while (requests_sent - first < 80)
        begin
            random_transfer();
        end
    endtask

    // Result sink: random stalls plus an occasional long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: disabled events, bare bus events, receive path
        issue(OP_TX_EMPTY, 8'hFF, 5'h1F);
        issue(OP_TX_END, 8'h00, 5'h00);
        issue(OP_START_SEEN, 8'h5A, 5'h0A);
        issue(OP_NACK, 8'hA5, 5'h15);
        issue(OP_RX_FULL, 8'hFF, 5'h1F);
        issue(OP_RX_FULL, 8'h00, 5'h00);
        issue(OP_STOP_SEEN, 8'h3C, 5'h11);

        // Fill the whole send buffer before any transfer can read it
        for (int i = 0; i < SEND_DEPTH; i++)
        begin
            issue(OP_LOAD, (i == 0) ? 8'h00 : (i == SEND_DEPTH - 1) ? 8'hFF : 8'($urandom),
                  5'(i));
        end

        // Write that never reaches its count: runs past the buffer
        program_transfer(1'b0, 6'd0, 5'd16);
        issue(OP_BEGIN, 8'h00, 5'h00);
        repeat (SEND_DEPTH + 1) step(OP_TX_EMPTY);
        step(OP_TX_END);
        step(OP_STOP_SEEN);

        // Read that runs past the receive buffer
        issue(OP_LOAD, 8'hA1, 5'd0);
        step(OP_BEGIN);
        step(OP_TX_EMPTY);
        step(OP_RX_FULL);
        repeat (RECV_DEPTH + 1) step(OP_RX_FULL);
        step(OP_STOP_SEEN);

        // Write-then-read with repeated start
        program_transfer(1'b1, 6'd0, 5'd2);
        step(OP_BEGIN);
        repeat (RESTART_AT) step(OP_TX_EMPTY);
        step(OP_TX_END);
        step(OP_START_SEEN);
        repeat (3) step(OP_RX_FULL);
        step(OP_STOP_SEEN);

        // Random phases, extremes of the settings first
        run_phase(1'b0, 6'd32, 5'd16, 0, 1'b0);
        run_phase(1'b1, 6'd0, 5'd1, 1, 1'b0);
        run_phase(1'b0, 6'd1, 5'd1, 2, 1'b1);
        run_phase(1'b1, 6'd32, 5'd16, 3, 1'b0);
        for (int p = 4; p < 8; p++)
        begin
            run_phase(1'($urandom_range(1)), 6'($urandom_range(32)),
                      5'($urandom_range(1, 16)), p % 4, 1'b0);
        end

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && pending_count != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
